@@ rtl/rrbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rrbm_pkg - ROM/RAM bank mapper shared definitions
// Request and response payload types, action codes and address map constants.
// ----------------------------------------------------------------------------
package rrbm_pkg;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_ROM_READ  = 3'd1,
      ACT_RAM_READ  = 3'd2,
      ACT_RAM_WRITE = 3'd3,
      ACT_OPEN_BUS  = 3'd4,
      ACT_REG_WRITE = 3'd5,
      ACT_RAM_DROP  = 3'd6
   } action_type;

   // register window, selected by address bits 14:13
   typedef enum logic [1:0] {
      REG_RAM_ENABLE = 2'd0,
      REG_ROM_BANK   = 2'd1,
      REG_RAM_BANK   = 2'd2,
      REG_BANK_MODE  = 2'd3
   } reg_sel_type;

   localparam int AddrWidth     = 16;
   localparam int DataWidth     = 8;
   localparam int MemAddrWidth  = 21;
   localparam int RomBankWidth  = 7;
   localparam int RamBankWidth  = 2;
   localparam int RomOffWidth   = 14;
   localparam int RamOffWidth   = 13;
   localparam int LowBankWidth  = 5;

   localparam logic [3:0]              RamEnableKey   = 4'hA;
   localparam logic [2:0]              RamWindowTop   = 3'b101;   // 0xA000-0xBFFF
   localparam logic [RomBankWidth-1:0] RomBankReset   = 7'd1;
   localparam logic [RomBankWidth-1:0] RomMaskReset   = 7'd1;

   typedef struct packed {
      logic                 mode;        // 0 read, 1 write
      logic [AddrWidth-1:0] address;
      logic [DataWidth-1:0] write_data;
   } req_payload_type;

   typedef struct packed {
      action_type              action;
      logic [MemAddrWidth-1:0] memory_address;
      logic [DataWidth-1:0]    ram_data;
   } rsp_payload_type;

endpackage

@@ rtl/rom_ram_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper - cartridge ROM/RAM bank mapper
// Path: an accepted request is held in the input register, then moves to the
//   result register once the output is free; the response comes from there.
// Throughput: one request per cycle unless the response stalls; bank registers
//   update in the same cycle that the request moves from input to result register.
// Reset: synchronous, active high; empties both stages, sets ROM bank and
//   mask to 1, RAM bank to 0, RAM disabled, simple banking mode.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rrbm_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rrbm_pkg::rsp_payload_type  rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [rrbm_pkg::RomBankWidth-1:0] csr_write_data
);

   logic                                req_valid_ff;
   rrbm_pkg::req_payload_type           req_payload_ff;
   logic                                rsp_valid_ff;
   rrbm_pkg::rsp_payload_type           rsp_payload_ff;
   rrbm_pkg::rsp_payload_type           rsp_payload_in;

   logic [rrbm_pkg::RomBankWidth-1:0]   rom_mask_ff;
   logic [rrbm_pkg::RomBankWidth-1:0]   rom_bank_ff;
   logic [rrbm_pkg::RomBankWidth-1:0]   rom_bank_in;
   logic [rrbm_pkg::RamBankWidth-1:0]   ram_bank_ff;
   logic [rrbm_pkg::RamBankWidth-1:0]   ram_bank_in;
   logic                                ram_enable_ff;
   logic                                ram_enable_in;
   logic                                bank_mode_ff;
   logic                                bank_mode_in;

   logic                                advance;
   logic [rrbm_pkg::RomBankWidth-1:0]   bank_cand;
   rrbm_pkg::reg_sel_type               reg_sel;
   logic                                in_low;
   logic                                in_ram;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign in_low  = !req_payload_ff.address[rrbm_pkg::AddrWidth-1];
   assign in_ram  = (req_payload_ff.address[rrbm_pkg::AddrWidth-1 -: 3] ==
                     rrbm_pkg::RamWindowTop);
   assign reg_sel = rrbm_pkg::reg_sel_type'(req_payload_ff.address[14:13]);

   always_comb begin
      // candidate ROM bank: upper bits from RAM bank only on large ROMs in mode 1
      bank_cand = {2'b00, req_payload_ff.write_data[rrbm_pkg::LowBankWidth-1:0]};
      if ((rom_mask_ff[6:5] != 2'b00) && bank_mode_ff) begin
         bank_cand[6:5] = ram_bank_ff;
      end
      bank_cand = bank_cand & rom_mask_ff;
      if (bank_cand[rrbm_pkg::LowBankWidth-1:0] == '0) begin
         bank_cand[0] = 1'b1;
      end
   end

   always_comb begin
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      ram_enable_in = ram_enable_ff;
      bank_mode_in  = bank_mode_ff;
      rsp_payload_in.action         = rrbm_pkg::ACT_NONE;
      rsp_payload_in.memory_address = '0;
      rsp_payload_in.ram_data       = '0;
      priority if (in_low) begin
         if (req_payload_ff.mode) begin
            rsp_payload_in.action = rrbm_pkg::ACT_REG_WRITE;
            unique case (reg_sel)
               rrbm_pkg::REG_RAM_ENABLE:
                  ram_enable_in = (req_payload_ff.write_data[3:0] == rrbm_pkg::RamEnableKey);
               rrbm_pkg::REG_ROM_BANK:   rom_bank_in  = bank_cand;
               rrbm_pkg::REG_RAM_BANK:
                  ram_bank_in = req_payload_ff.write_data[rrbm_pkg::RamBankWidth-1:0];
               rrbm_pkg::REG_BANK_MODE:  bank_mode_in = req_payload_ff.write_data[0];
               default: ;
            endcase
         end else begin
            rsp_payload_in.action = rrbm_pkg::ACT_ROM_READ;
            if (!req_payload_ff.address[rrbm_pkg::RomOffWidth]) begin
               rsp_payload_in.memory_address = {5'd0, req_payload_ff.address};
            end else begin
               rsp_payload_in.memory_address =
                  {rom_bank_ff, req_payload_ff.address[rrbm_pkg::RomOffWidth-1:0]};
            end
         end
      end else if (in_ram) begin
         if (ram_enable_ff) begin
            rsp_payload_in.memory_address =
               {6'd0, ram_bank_ff, req_payload_ff.address[rrbm_pkg::RamOffWidth-1:0]};
            if (req_payload_ff.mode) begin
               rsp_payload_in.action   = rrbm_pkg::ACT_RAM_WRITE;
               rsp_payload_in.ram_data = req_payload_ff.write_data;
            end else begin
               rsp_payload_in.action   = rrbm_pkg::ACT_RAM_READ;
            end
         end else begin
            // disabled RAM: open bus on read, drop the write
            rsp_payload_in.action = req_payload_ff.mode ? rrbm_pkg::ACT_RAM_DROP
                                                        : rrbm_pkg::ACT_OPEN_BUS;
         end
      end else begin
         rsp_payload_in.action = rrbm_pkg::ACT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rom_mask_ff   <= rrbm_pkg::RomMaskReset;
         rom_bank_ff   <= rrbm_pkg::RomBankReset;
         ram_bank_ff   <= '0;
         ram_enable_ff <= 1'b0;
         bank_mode_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            rom_mask_ff <= csr_write_data;
         end
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
            // commit bank registers only as the request leaves the input stage
            if (req_valid_ff) begin
               rom_bank_ff   <= rom_bank_in;
               ram_bank_ff   <= ram_bank_in;
               ram_enable_ff <= ram_enable_in;
               bank_mode_ff  <= bank_mode_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_payload_ff <= req_payload;
      end
      if (advance && req_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

@@ rtl/rom_ram_bank_mapper_checker.sv @@
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_checker - port level checks on the bank mapper
// Watches the response channel for handshake and payload consistency, and request stalls.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input rrbm_pkg::rsp_payload_type  rsp_payload
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // no response can appear the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action != rrbm_pkg::ACT_RAM_WRITE)
      |-> rsp_payload.ram_data == '0)
      else $error("ram data set on a non-write action");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.action == rrbm_pkg::ACT_NONE ||
                    rsp_payload.action == rrbm_pkg::ACT_OPEN_BUS ||
                    rsp_payload.action == rrbm_pkg::ACT_REG_WRITE ||
                    rsp_payload.action == rrbm_pkg::ACT_RAM_DROP)
      |-> rsp_payload.memory_address == '0)
      else $error("address set on an action without memory access");

   // stall the request side only behind a held response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a held response");

endmodule

bind rom_ram_bank_mapper rom_ram_bank_mapper_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

@@ verif/tb_rom_ram_bank_mapper.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rom_ram_bank_mapper - self-checking bench for the cartridge bank mapper
// Drives CPU bus requests through the valid/ready request channel, predicts
// every mapped response with a behavioural copy of the bank registers, and
// compares responses in order. Covers the address map edges, each register
// window, several ROM bank mask settings and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_rom_ram_bank_mapper;

   localparam int CycleLimit    = 300000;
   localparam int PrintLimit    = 40;
   localparam int PhaseRequests = 150;

   logic                              clock            = 1'b0;
   logic                              reset            = 1'b1;
   logic                              req_valid        = 1'b0;
   logic                              req_ready;
   rrbm_pkg::req_payload_type         req_payload      = '0;
   logic                              rsp_valid;
   logic                              rsp_ready        = 1'b0;
   rrbm_pkg::rsp_payload_type         rsp_payload;
   logic                              csr_write_enable = 1'b0;
   logic [rrbm_pkg::RomBankWidth-1:0] csr_write_data   = '0;

   // behavioural copy of the mapper registers
   logic [rrbm_pkg::RomBankWidth-1:0] bank_mask    = rrbm_pkg::RomMaskReset;
   logic [rrbm_pkg::RomBankWidth-1:0] rom_bank_sel = rrbm_pkg::RomBankReset;
   logic [rrbm_pkg::RamBankWidth-1:0] ram_bank_sel = '0;
   logic                              ram_on       = 1'b0;
   logic                              banking_mode = 1'b0;

   rrbm_pkg::rsp_payload_type pending_mappings[$];

   int mismatches        = 0;
   int requests_issued   = 0;
   int responses_checked = 0;
   int mask_settings     = 0;
   int cycle_count       = 0;
   int src_idle_pct      = 25;
   int sink_idle_pct     = 25;
   int hold_off_left     = 0;
   int action_seen[7];

   rom_ram_bank_mapper dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  pending_mappings.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: hold off while a stall is counted down, else idle at random
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= PrintLimit)
         $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_responses
      rrbm_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_mappings.size() == 0) begin
            report_mismatch("unexpected response action", 32'(rsp_payload.action), 32'd0);
         end else begin
            want = pending_mappings.pop_front();
            if (rsp_payload.action !== want.action)
               report_mismatch("action", 32'(rsp_payload.action), 32'(want.action));
            if (rsp_payload.memory_address !== want.memory_address)
               report_mismatch("memory_address", 32'(rsp_payload.memory_address),
                               32'(want.memory_address));
            if (rsp_payload.ram_data !== want.ram_data)
               report_mismatch("ram_data", 32'(rsp_payload.ram_data), 32'(want.ram_data));
            if (want.action <= rrbm_pkg::ACT_RAM_DROP)
               action_seen[want.action]++;
            responses_checked++;
         end
      end
   end

   // decode one bus access and apply any register write
   task automatic map_access(input rrbm_pkg::req_payload_type acc,
                             output rrbm_pkg::rsp_payload_type res);
      logic [rrbm_pkg::RomBankWidth-1:0] cand;
      res = '0;
      res.action = rrbm_pkg::ACT_NONE;
      if (!acc.address[15]) begin
         if (acc.mode) begin
            res.action = rrbm_pkg::ACT_REG_WRITE;
            case (rrbm_pkg::reg_sel_type'(acc.address[14:13]))
               rrbm_pkg::REG_RAM_ENABLE:
                  ram_on = (acc.write_data[3:0] == rrbm_pkg::RamEnableKey);
               rrbm_pkg::REG_ROM_BANK: begin
                  cand = {2'b00, acc.write_data[rrbm_pkg::LowBankWidth-1:0]};
                  if (bank_mask > 7'h1F && banking_mode)
                     cand[6:5] = ram_bank_sel;
                  cand = cand & bank_mask;
                  if (cand[rrbm_pkg::LowBankWidth-1:0] == '0)
                     cand = cand + 7'd1;
                  rom_bank_sel = cand;
               end
               rrbm_pkg::REG_RAM_BANK:
                  ram_bank_sel = acc.write_data[rrbm_pkg::RamBankWidth-1:0];
               default: banking_mode = acc.write_data[0];
            endcase
         end else begin
            res.action = rrbm_pkg::ACT_ROM_READ;
            if (!acc.address[14])
               res.memory_address = rrbm_pkg::MemAddrWidth'(acc.address);
            else
               res.memory_address = {rom_bank_sel, acc.address[rrbm_pkg::RomOffWidth-1:0]};
         end
      end else if (acc.address[15:13] == rrbm_pkg::RamWindowTop) begin
         if (ram_on) begin
            res.memory_address = rrbm_pkg::MemAddrWidth'(
               {ram_bank_sel, acc.address[rrbm_pkg::RamOffWidth-1:0]});
            if (acc.mode) begin
               res.action   = rrbm_pkg::ACT_RAM_WRITE;
               res.ram_data = acc.write_data;
            end else begin
               res.action = rrbm_pkg::ACT_RAM_READ;
            end
         end else begin
            res.action = acc.mode ? rrbm_pkg::ACT_RAM_DROP : rrbm_pkg::ACT_OPEN_BUS;
         end
      end
   endtask

   function automatic rrbm_pkg::req_payload_type bus_access(input logic mode,
                                                            input logic [15:0] addr,
                                                            input logic [7:0] data);
      rrbm_pkg::req_payload_type acc;
      acc.mode       = mode;
      acc.address    = addr;
      acc.write_data = data;
      return acc;
   endfunction

   function automatic rrbm_pkg::req_payload_type random_access();
      rrbm_pkg::req_payload_type acc;
      int pick;
      pick           = $urandom_range(99);
      acc.mode       = 1'($urandom_range(1));
      acc.write_data = 8'($urandom_range(255));
      if (pick < 30) begin
         acc.mode    = 1'b1;
         acc.address = 16'($urandom_range(16'h7FFF));
         if ($urandom_range(1))
            acc.write_data[3:0] = rrbm_pkg::RamEnableKey;
      end else if (pick < 55) begin
         acc.mode    = 1'b0;
         acc.address = 16'($urandom_range(16'h7FFF));
      end else if (pick < 85) begin
         acc.address = 16'($urandom_range(16'hBFFF, 16'hA000));
      end else begin
         acc.address = 16'($urandom_range(16'hFFFF));
      end
      return acc;
   endfunction

   // offer one request, hold it until accepted, then queue its prediction
   task automatic issue_access(input rrbm_pkg::req_payload_type acc);
      rrbm_pkg::rsp_payload_type res;
      while ($urandom_range(99) < src_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= acc;
      do @(posedge clock); while (!req_ready);
      map_access(acc, res);
      pending_mappings.push_back(res);
      requests_issued++;
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_mappings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_bank_mask(input logic [rrbm_pkg::RomBankWidth-1:0] mask);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mask;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      bank_mask = mask;
      mask_settings++;
   endtask

   task automatic test_reset_defaults();
      issue_access(bus_access(1'b0, 16'h0000, 8'h00));
      issue_access(bus_access(1'b0, 16'h3FFF, 8'hFF));
      issue_access(bus_access(1'b0, 16'h4000, 8'h00));
      issue_access(bus_access(1'b0, 16'h7FFF, 8'hFF));
      issue_access(bus_access(1'b0, 16'hA000, 8'h00));
      issue_access(bus_access(1'b1, 16'hBFFF, 8'hFF));
      issue_access(bus_access(1'b1, 16'h8000, 8'h55));
      issue_access(bus_access(1'b0, 16'h9FFF, 8'h00));
      issue_access(bus_access(1'b0, 16'hC000, 8'hFF));
      issue_access(bus_access(1'b1, 16'hFFFF, 8'hAA));
      wait_for_idle();
   endtask

   task automatic test_register_windows();
      set_bank_mask(7'h7F);
      issue_access(bus_access(1'b1, 16'h1FFF, 8'h5A));   // only the low nibble is keyed
      issue_access(bus_access(1'b1, 16'h5FFF, 8'hFF));
      issue_access(bus_access(1'b1, 16'h7FFF, 8'h01));
      issue_access(bus_access(1'b1, 16'h2000, 8'hE0));   // zero low bank bumps by one
      issue_access(bus_access(1'b0, 16'h7FFF, 8'h00));
      issue_access(bus_access(1'b1, 16'hA000, 8'hFF));
      issue_access(bus_access(1'b0, 16'hBFFF, 8'h00));
      issue_access(bus_access(1'b1, 16'h0000, 8'h0B));
      issue_access(bus_access(1'b0, 16'hA000, 8'h00));
      issue_access(bus_access(1'b1, 16'h6000, 8'h00));
      issue_access(bus_access(1'b1, 16'h3FFF, 8'h1F));
      issue_access(bus_access(1'b0, 16'h4000, 8'h00));
      wait_for_idle();
   endtask

   task automatic test_mask_sweep();
      logic [rrbm_pkg::RomBankWidth-1:0] masks[7];
      masks = '{7'h00, 7'h1F, 7'h20, 7'h3F, 7'h01, 7'h00, 7'h7F};
      masks[5] = 7'($urandom_range(127, 1));
      foreach (masks[i]) begin
         set_bank_mask(masks[i]);
         // one stretch runs flat out on both sides
         src_idle_pct  = (i == 3) ? 0 : 25;
         sink_idle_pct = (i == 3) ? 0 : 25;
         // read through the old bank first: a mask change alone must not remap it
         issue_access(bus_access(1'b0, 16'($urandom_range(16'h7FFF, 16'h4000)), 8'h00));
         repeat (PhaseRequests) issue_access(random_access());
         wait_for_idle();
      end
      src_idle_pct  = 25;
      sink_idle_pct = 25;
   endtask

   task automatic test_backpressure();
      hold_off_left = 80;
      repeat (40) issue_access(random_access());
      // pause the request side until everything has drained
      wait_for_idle();
      repeat (30) issue_access(random_access());
      wait_for_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_windows();
      test_mask_sweep();
      test_backpressure();

      repeat (10) @(posedge clock);
      $display("%0d requests issued, %0d responses checked over %0d mask settings",
               requests_issued, responses_checked, mask_settings);
      $display("actions: none %0d, rom rd %0d, ram rd %0d, ram wr %0d,",
               action_seen[0], action_seen[1], action_seen[2], action_seen[3]);
      $display("         open bus %0d, reg wr %0d, dropped %0d",
               action_seen[4], action_seen[5], action_seen[6]);
      if (mismatches == 0 && pending_mappings.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches,
                  pending_mappings.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
